// File: rtl/bfsa_pkg.sv
package bfsa_pkg;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_INIT    = 3'd1;
    localparam logic [2:0] ST_ALREADY     = 3'd2;
    localparam logic [2:0] ST_TOO_SMALL   = 3'd3;
    localparam logic [2:0] ST_NULL_BASE   = 3'd4;
    localparam logic [2:0] ST_NO_FIT      = 3'd5;
    localparam logic [2:0] ST_NOT_ALLOC   = 3'd6;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic decide;
        logic shift;
        logic fix1;
        logic fix2;
        logic resp;
    } bfsa_ctrl_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic go_shift;
        logic go_fix;
        logic fix_two;
        logic out_free;
    } bfsa_stat_t;

endpackage

// File: rtl/best_fit_segment_allocator.sv
// channel   dir  handshake             payload
// in        in   in_valid / in_ready   command, req_size, address
// out       out  out_valid / out_ready status, result_address
// cfg       in   cfg_valid / cfg_ready cfg_data (pool_base)
//
// one request at a time: a scan of the segment table, a decide step, an
// entry shift when needed (one table entry per cycle through the single
// read and write port), then fix-up and response
// rst_n clears the controller, pool state and the output valid flag at once;
// the segment table holds no reset, only entries below the count are read
// a stalled result stays in the output register; no new request is taken
// until the previous result has been loaded there
module best_fit_segment_allocator
    import bfsa_pkg::*;
#(
    parameter int MAX_SEGMENTS   = 64,
    parameter int HEADER_BYTES   = 16,
    parameter int POOL_SIZE_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [19:0] req_size,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] result_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    bfsa_ctrl_t ctrl;
    bfsa_stat_t stat;

    // pool_base can be written any time
    assign cfg_ready = 1'b1;

    // sequencer for scan, decide, shift, fix-up and response phases
    bfsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // segment table, best-fit search and coalescing arithmetic
    bfsa_dp #(
        .MAX_SEGMENTS   (MAX_SEGMENTS),
        .HEADER_BYTES   (HEADER_BYTES),
        .POOL_SIZE_BITS (POOL_SIZE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .command        (command),
        .req_size       (req_size),
        .address        (address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_address (result_address)
    );

endmodule

// File: rtl/bfsa_ctrl.sv
module bfsa_ctrl
    import bfsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  bfsa_stat_t stat,
    output bfsa_ctrl_t ctrl
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_SHIFT  = 7'b0001000,
        S_FIX1   = 7'b0010000,
        S_FIX2   = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (stat.scan_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                ctrl.decide = 1'b1;
                priority if (stat.go_shift)
                    state_next = S_SHIFT;
                else if (stat.go_fix)
                    state_next = S_FIX1;
                else
                    state_next = S_RESP;
            end
            S_SHIFT:
            begin
                ctrl.shift = 1'b1;
                if (stat.shift_done)
                    state_next = S_FIX1;
            end
            S_FIX1:
            begin
                ctrl.fix1 = 1'b1;
                state_next = stat.fix_two ? S_FIX2 : S_RESP;
            end
            S_FIX2:
            begin
                ctrl.fix2 = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                ctrl.resp = 1'b1;
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/bfsa_dp.sv
module bfsa_dp
    import bfsa_pkg::*;
#(
    parameter int MAX_SEGMENTS   = 64,
    parameter int HEADER_BYTES   = 16,
    parameter int POOL_SIZE_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  bfsa_ctrl_t  ctrl,
    output bfsa_stat_t  stat,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    input  logic [1:0]  command,
    input  logic [19:0] req_size,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] result_address
);

    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int SW = POOL_SIZE_BITS;
    localparam logic [31:0] HDR  = 32'(HEADER_BYTES);
    localparam logic [31:0] MASK = 32'((64'd1 << POOL_SIZE_BITS) - 64'd1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

    // segment table
    logic [SW-1:0] mem_off  [MAX_SEGMENTS];
    logic [SW-1:0] mem_size [MAX_SEGMENTS];
    logic          mem_used [MAX_SEGMENTS];

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [SW-1:0] wr_off, wr_size;
    logic          wr_used;
    logic [IW-1:0] rd_addr;
    logic [SW-1:0] rd_off_q, rd_size_q;
    logic          rd_used_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_off[wr_addr]  <= wr_off;
            mem_size[wr_addr] <= wr_size;
            mem_used[wr_addr] <= wr_used;
        end
        rd_off_q  <= mem_off[rd_addr];
        rd_size_q <= mem_size[rd_addr];
        rd_used_q <= mem_used[rd_addr];
    end

    logic [31:0]   base_reg;
    logic          ready_reg;
    logic [SW-1:0] pbytes_reg;
    logic [CW-1:0] count_reg;
    logic [1:0]    cmd_reg;
    logic [19:0]   req_reg;
    logic [31:0]   rel_reg;
    logic [CW-1:0] k_reg;
    logic          scan_pend_reg, sh_pend_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          found_reg, f_used_reg;
    logic [IW-1:0] f_idx_reg;
    logic [SW-1:0] f_off_reg, f_size_reg;
    logic          last_used_reg, prev_used_reg, next_used_reg;
    logic [SW-1:0] last_off_reg, prev_off_reg, next_off_reg, nn_off_reg;
    logic [CW-1:0] sh_src_reg, sh_n_reg;
    logic          sh_up_reg;
    logic [1:0]    sh_r_reg;
    logic          split_reg;
    logic [IW-1:0] s_idx_reg;
    logic [SW-1:0] s_off_reg, s_size_reg;
    logic [2:0]    res_status_reg;
    logic [31:0]   res_addr_reg;
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [31:0]   out_addr_reg;

    // scan compare on returning entry
    logic [31:0] req32, rd_size32, f_size32;
    logic        alloc_hit, free_hit, is_next, is_nn;
    assign req32     = {12'd0, req_reg};
    assign rd_size32 = 32'(rd_size_q);
    assign f_size32  = 32'(f_size_reg);
    assign alloc_hit = !rd_used_q && (rd_size32 >= req32) &&
                       (!found_reg || (rd_size_q < f_size_reg));
    assign free_hit  = !found_reg && (32'(rd_off_q) == rel_reg);
    assign is_next   = found_reg && (CW'(rd_idx_reg) == CW'(f_idx_reg) + CW'(1));
    assign is_nn     = found_reg && (CW'(rd_idx_reg) == CW'(f_idx_reg) + CW'(2));

    // decision
    logic [31:0]   rem32, end32, new_size32, sat32;
    logic          split, pm, nm, free_ok;
    logic [IW-1:0] s_idx;
    logic [SW-1:0] s_off;
    logic [1:0]    r_cnt;
    logic [CW:0]   after_idx;
    logic [CW-1:0] up_n, dn_n;
    logic [2:0]    dec_status;

    assign rem32   = f_size32 - req32;
    assign split   = (rem32 > HDR) && (count_reg < CNT_MAX);
    assign free_ok = found_reg && f_used_reg;
    assign pm      = (f_idx_reg != '0) && !prev_used_reg;
    assign nm      = ((CW'(f_idx_reg) + CW'(1)) < count_reg) && !next_used_reg;
    assign s_idx   = pm ? (f_idx_reg - IW'(1)) : f_idx_reg;
    assign s_off   = pm ? prev_off_reg : f_off_reg;
    assign r_cnt   = {1'b0, pm} + {1'b0, nm};
    assign after_idx = (CW+1)'(f_idx_reg) + (CW+1)'(1) + (CW+1)'(nm);
    assign end32   = (after_idx < (CW+1)'(count_reg)) ?
                     32'(nm ? nn_off_reg : next_off_reg) : 32'(pbytes_reg);
    assign new_size32 = end32 - 32'(s_off) - HDR;
    assign up_n    = count_reg - CW'(1) - CW'(f_idx_reg);
    assign dn_n    = count_reg - CW'(1) - CW'(s_idx) - CW'(r_cnt);
    assign sat32   = (req32 > MASK) ? MASK : req32;

    always_comb
    begin
        dec_status = ST_OK;
        unique case (cmd_reg)
            CMD_INIT:
            begin
                priority if (ready_reg)
                    dec_status = ST_ALREADY;
                else if (req32 < HDR)
                    dec_status = ST_TOO_SMALL;
                else if (base_reg == '0)
                    dec_status = ST_NULL_BASE;
                else
                    dec_status = ST_OK;
            end
            CMD_ALLOC:
            begin
                priority if (!ready_reg)
                    dec_status = ST_NOT_INIT;
                else if (!found_reg)
                    dec_status = ST_NO_FIT;
                else
                    dec_status = ST_OK;
            end
            CMD_FREE:
            begin
                priority if (!ready_reg)
                    dec_status = ST_NOT_INIT;
                else if (!free_ok)
                    dec_status = ST_NOT_ALLOC;
                else
                    dec_status = ST_OK;
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    logic work;
    assign work = ready_reg && (dec_status == ST_OK) &&
                  ((cmd_reg == CMD_ALLOC) || (cmd_reg == CMD_FREE));

    assign stat.scan_done  = (k_reg == count_reg) && !scan_pend_reg;
    assign stat.shift_done = (sh_n_reg == '0) && !sh_pend_reg;
    assign stat.go_fix     = work;
    assign stat.go_shift   = work && ((cmd_reg == CMD_ALLOC) ? (split && (up_n != '0))
                                                             : (dn_n != '0));
    assign stat.fix_two    = split_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // read address and write port
    assign rd_addr = ctrl.shift ? sh_src_reg[IW-1:0] : k_reg[IW-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_off  = '0;
        wr_size = '0;
        wr_used = 1'b0;
        priority if (ctrl.decide && (cmd_reg == CMD_INIT) && (dec_status == ST_OK))
        begin
            wr_en   = 1'b1;
            wr_size = SW'(sat32 - HDR);
        end
        else if (sh_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = sh_up_reg ? (rd_idx_reg + IW'(1)) : (rd_idx_reg - IW'(sh_r_reg));
            wr_off  = rd_off_q;
            wr_size = rd_size_q;
            wr_used = rd_used_q;
        end
        else if (ctrl.fix1 && (cmd_reg == CMD_FREE))
        begin
            wr_en   = 1'b1;
            wr_addr = s_idx_reg;
            wr_off  = s_off_reg;
            wr_size = s_size_reg;
        end
        else if (ctrl.fix1 && split_reg)
        begin
            // free remainder behind the granted segment
            wr_en   = 1'b1;
            wr_addr = f_idx_reg + IW'(1);
            wr_off  = SW'(32'(f_off_reg) + HDR + req32);
            wr_size = SW'(rem32 - HDR);
        end
        else if (ctrl.fix1 || ctrl.fix2)
        begin
            wr_en   = 1'b1;
            wr_addr = f_idx_reg;
            wr_off  = f_off_reg;
            wr_size = split_reg ? SW'(req32) : f_size_reg;
            wr_used = 1'b1;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    // payload-style registers
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            cmd_reg <= command;
            req_reg <= req_size;
            rel_reg <= address - HDR - base_reg;
        end
        if (scan_pend_reg)
        begin
            if (cmd_reg == CMD_ALLOC && alloc_hit)
            begin
                f_idx_reg  <= rd_idx_reg;
                f_off_reg  <= rd_off_q;
                f_size_reg <= rd_size_q;
            end
            if (cmd_reg == CMD_FREE)
            begin
                if (free_hit)
                begin
                    f_idx_reg     <= rd_idx_reg;
                    f_off_reg     <= rd_off_q;
                    f_used_reg    <= rd_used_q;
                    prev_used_reg <= last_used_reg;
                    prev_off_reg  <= last_off_reg;
                end
                if (is_next)
                begin
                    next_used_reg <= rd_used_q;
                    next_off_reg  <= rd_off_q;
                end
                if (is_nn)
                    nn_off_reg <= rd_off_q;
                last_used_reg <= rd_used_q;
                last_off_reg  <= rd_off_q;
            end
        end
        if (ctrl.decide)
        begin
            res_status_reg <= dec_status;
            res_addr_reg   <= (work && cmd_reg == CMD_ALLOC) ?
                              (base_reg + 32'(f_off_reg) + HDR) : '0;
            split_reg      <= work && (cmd_reg == CMD_ALLOC) && split;
            s_idx_reg      <= s_idx;
            s_off_reg      <= s_off;
            s_size_reg     <= SW'(new_size32);
            sh_r_reg       <= r_cnt;
            sh_up_reg      <= (cmd_reg == CMD_ALLOC);
        end
        if (ctrl.resp && stat.out_free)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            ready_reg     <= 1'b0;
            pbytes_reg    <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            scan_pend_reg <= 1'b0;
            sh_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            found_reg     <= 1'b0;
            sh_src_reg    <= '0;
            sh_n_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                base_reg <= cfg_data;
            if (ctrl.start)
            begin
                k_reg     <= '0;
                found_reg <= 1'b0;
            end
            if (ctrl.scan && (k_reg != count_reg))
            begin
                scan_pend_reg <= 1'b1;
                rd_idx_reg    <= k_reg[IW-1:0];
                k_reg         <= k_reg + CW'(1);
            end
            else
            begin
                scan_pend_reg <= 1'b0;
            end
            if (scan_pend_reg && ((cmd_reg == CMD_ALLOC && alloc_hit) ||
                                  (cmd_reg == CMD_FREE && free_hit)))
                found_reg <= 1'b1;
            if (ctrl.decide)
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    sh_src_reg <= count_reg - CW'(1);
                    sh_n_reg   <= split ? up_n : '0;
                end
                else
                begin
                    sh_src_reg <= CW'(s_idx) + CW'(1) + CW'(r_cnt);
                    sh_n_reg   <= dn_n;
                end
                if (cmd_reg == CMD_INIT && dec_status == ST_OK)
                begin
                    ready_reg  <= 1'b1;
                    pbytes_reg <= SW'(sat32);
                    count_reg  <= CW'(1);
                end
            end
            if (ctrl.shift && (sh_n_reg != '0))
            begin
                sh_pend_reg <= 1'b1;
                rd_idx_reg  <= sh_src_reg[IW-1:0];
                sh_src_reg  <= sh_up_reg ? (sh_src_reg - CW'(1)) : (sh_src_reg + CW'(1));
                sh_n_reg    <= sh_n_reg - CW'(1);
            end
            else
            begin
                sh_pend_reg <= 1'b0;
            end
            if (ctrl.fix1)
            begin
                if (cmd_reg == CMD_FREE)
                    count_reg <= count_reg - CW'(sh_r_reg);
                else if (split_reg)
                    count_reg <= count_reg + CW'(1);
            end
            if (ctrl.resp && stat.out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign result_address = out_addr_reg;

endmodule

// File: rtl/bfsa_checker.sv
module bfsa_checker
    import bfsa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [31:0] result_address
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_address))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_NOT_ALLOC)
        else $error("status code out of range");

    // only a granted allocate carries an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result_address == 32'd0)
        else $error("address on failed request");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .result_address (result_address)
);
